// ----- design/cpfm_pkg.sv -----
// Shared constants and controller/datapath interface types for the capture pair
// frequency meter. No dependencies.
package cpfm_pkg;

    localparam int CAP_W    = 16;             // capture value and period width
    localparam int CLK_W    = 28;             // timer clock register width
    localparam int FREQ_W   = 30;             // frequency result width
    localparam int COUNTER_BITS    = 16;      // width of the capture timer counter
    localparam int PRESCALE_FACTOR = 4;       // capture input prescale

    localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(72000000);

    // The period wraps at the counter width, never wider than a capture value.
    localparam int PERIOD_W = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;
    localparam logic [CAP_W-1:0] PERIOD_MASK = CAP_W'((33'd1 << PERIOD_W) - 33'd1);

    // Divider: one quotient bit per step, one step per clock bit.
    localparam int DIV_STEPS = CLK_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam int PS_W   = $clog2(PRESCALE_FACTOR + 1);
    localparam int PROD_W = CLK_W + PS_W + 1;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef struct packed {
        logic accept;     // take the input request and update the pairing state
        logic div_step;   // one restoring division step
        logic scale;      // apply prescale and saturation, store the frequency
        logic out_load;   // move the result registers into the output register
    } t_cmd;

    typedef struct packed {
        logic need_div;   // the request completes a pair with a nonzero period
        logic div_last;   // the current division step is the final one
    } t_sts;

endpackage

// ----- design/cpfm_dpath.sv -----
// Datapath of the capture pair frequency meter: pairing state, period,
// bit-serial divider, prescale and output register. Depends on cpfm_pkg.
module cpfm_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cpfm_pkg::CLK_W-1:0]    i_cfg_wr_data,
    input  logic                          i_opcode,
    input  logic [cpfm_pkg::CAP_W-1:0]    i_capture_value,
    input  cpfm_pkg::t_cmd                i_cmd,
    output cpfm_pkg::t_sts                o_sts,
    output logic [cpfm_pkg::FREQ_W-1:0]   o_frequency_hz,
    output logic [cpfm_pkg::CAP_W-1:0]    o_period_ticks,
    output logic                          o_updated,
    output logic                          o_zero_period
);

    logic [cpfm_pkg::CLK_W-1:0]  r_clk_hz;
    logic                        r_phase;
    logic [cpfm_pkg::CAP_W-1:0]  r_first;
    logic [cpfm_pkg::CAP_W-1:0]  r_period;
    logic [cpfm_pkg::FREQ_W-1:0] r_freq;
    logic                        r_upd;
    logic                        r_zero;
    logic [cpfm_pkg::CAP_W-1:0]  r_rem;
    logic [cpfm_pkg::CLK_W-1:0]  r_quo;
    logic [cpfm_pkg::DCNT_W-1:0] r_cnt;
    logic [cpfm_pkg::FREQ_W-1:0] r_out_freq;
    logic [cpfm_pkg::CAP_W-1:0]  r_out_period;
    logic                        r_out_upd;
    logic                        r_out_zero;

    logic [cpfm_pkg::CAP_W-1:0]  diff;
    logic [cpfm_pkg::CAP_W:0]    trial;
    logic                        fits;
    logic [cpfm_pkg::PROD_W-1:0] prod;

    assign diff  = (i_capture_value - r_first) & cpfm_pkg::PERIOD_MASK;
    assign trial = {r_rem, r_quo[cpfm_pkg::CLK_W-1]};
    assign fits  = (trial >= {1'b0, r_period});
    assign prod  = cpfm_pkg::PROD_W'(r_quo)
                 * cpfm_pkg::PROD_W'(cpfm_pkg::PRESCALE_FACTOR);

    assign o_sts.need_div = (i_opcode == cpfm_pkg::OP_CAPTURE) && r_phase && (diff != '0);
    assign o_sts.div_last = (r_cnt == cpfm_pkg::DCNT_W'(cpfm_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= cpfm_pkg::CLK_RESET;
            r_phase  <= 1'b0;
            r_first  <= '0;
            r_period <= '0;
            r_freq   <= '0;
            r_upd    <= 1'b0;
            r_zero   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_clk_hz <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                r_upd  <= 1'b0;
                r_zero <= 1'b0;
                if (i_opcode == cpfm_pkg::OP_CLEAR) begin
                    r_phase <= 1'b0;
                    r_freq  <= '0;
                end else if (!r_phase) begin
                    r_first <= i_capture_value;
                    r_phase <= 1'b1;
                end else begin
                    r_phase  <= 1'b0;
                    r_period <= diff;
                    r_upd    <= 1'b1;
                    r_cnt    <= '0;
                    if (diff == '0) begin
                        r_zero <= 1'b1;
                        r_freq <= '0;
                    end
                end
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.scale) begin
                r_freq <= (prod > cpfm_pkg::PROD_W'(cpfm_pkg::FREQ_MAX))
                        ? cpfm_pkg::FREQ_MAX : prod[cpfm_pkg::FREQ_W-1:0];
            end
        end
    end

    // Restoring divider: the dividend shifts out of r_quo as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rem <= '0;
            r_quo <= r_clk_hz;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? cpfm_pkg::CAP_W'(trial - {1'b0, r_period})
                          : trial[cpfm_pkg::CAP_W-1:0];
            r_quo <= {r_quo[cpfm_pkg::CLK_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_freq   <= r_freq;
            r_out_period <= r_period;
            r_out_upd    <= r_upd;
            r_out_zero   <= r_zero;
        end
    end

    assign o_frequency_hz = r_out_freq;
    assign o_period_ticks = r_out_period;
    assign o_updated      = r_out_upd;
    assign o_zero_period  = r_out_zero;

endmodule

// ----- design/cpfm_ctrl.sv -----
// Controller of the capture pair frequency meter: sequences acceptance,
// division, scaling and result hand-off. Depends on cpfm_pkg.
module cpfm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  cpfm_pkg::t_sts i_sts,
    output cpfm_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCALE,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free          = !r_out_valid || i_out_ready;
    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_cmd.accept      = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.div_step    = (r_state == S_DIV);
    assign o_cmd.scale       = (r_state == S_SCALE);
    assign o_cmd.out_load    = (r_state == S_EMIT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.accept) begin
                        r_state <= i_sts.need_div ? S_DIV : S_EMIT;
                    end
                end
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && r_out_valid) |-> i_out_ready)
        else $error("pending result overwritten");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> !o_in_ready)
        else $error("new request taken before the previous one finished");

    a_div_then_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_step && i_sts.div_last) |=> o_cmd.scale)
        else $error("scaling did not follow the last division step");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

// ----- design/capture_pair_frequency_meter.sv -----
// Top level of the capture pair frequency meter: controller plus datapath.
// Depends on cpfm_pkg, cpfm_ctrl and cpfm_dpath.
//
// Usage: requests arrive on the input channel (i_in_valid / o_in_ready) with
// an opcode (capture or clear) and a 16-bit capture value. Every request yields
// exactly one result on the output channel (o_out_valid / i_out_ready) holding
// the latest frequency, latest period, and the updated and zero-period flags.
// The timer clock register is written through i_cfg_wr_en / i_cfg_wr_data;
// the user must do so only while the block is idle; the block does not check.
// A request that completes a pair with a nonzero period passes through the 28
// steps of the bit-serial divider, a scaling step and the output load before
// its result is presented; any other request goes straight to the output load.
// The divider produces one quotient bit per cycle over the 28-bit clock value.
// A new request is taken only once the previous result sits in the output
// register. When the receiver stalls, the result waits in the output register
// and the next request is still taken; its own result then waits for that slot.
// Reset clears the pairing state, period, frequency and output valid, and
// restores the timer clock register to 72 MHz.
module capture_pair_frequency_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cpfm_pkg::CLK_W-1:0]    i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [cpfm_pkg::CAP_W-1:0]    i_capture_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cpfm_pkg::FREQ_W-1:0]   o_frequency_hz,
    output logic [cpfm_pkg::CAP_W-1:0]    o_period_ticks,
    output logic                          o_updated,
    output logic                          o_zero_period
);

    cpfm_pkg::t_cmd cmd;
    cpfm_pkg::t_sts sts;

    cpfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cpfm_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_opcode        (i_opcode),
        .i_capture_value (i_capture_value),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_frequency_hz  (o_frequency_hz),
        .o_period_ticks  (o_period_ticks),
        .o_updated       (o_updated),
        .o_zero_period   (o_zero_period)
    );

endmodule

// ----- test/tb_capture_pair_frequency_meter.sv -----
// Self-checking testbench for capture_pair_frequency_meter: a directed table of
// requests, then random capture pairs under several timer clock settings.
// Depends on cpfm_pkg and the capture_pair_frequency_meter RTL.
module tb_capture_pair_frequency_meter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP_W  = cpfm_pkg::CAP_W;
    localparam int CLK_W  = cpfm_pkg::CLK_W;
    localparam int FREQ_W = cpfm_pkg::FREQ_W;
    localparam int PRESCALE_FACTOR = cpfm_pkg::PRESCALE_FACTOR;
    localparam logic OP_CAPTURE = cpfm_pkg::OP_CAPTURE;
    localparam logic OP_CLEAR   = cpfm_pkg::OP_CLEAR;
    localparam logic [CLK_W-1:0]  CLK_RESET   = cpfm_pkg::CLK_RESET;
    localparam logic [CAP_W-1:0]  PERIOD_MASK = cpfm_pkg::PERIOD_MASK;
    localparam logic [FREQ_W-1:0] FREQ_MAX    = cpfm_pkg::FREQ_MAX;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 140;
    localparam int NUM_ROWS       = 27;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic [CAP_W-1:0]  period;
        logic              updated;
        logic              zero_period;
    } t_meter_reading;

    typedef enum logic {
        ROW_REQUEST,
        ROW_CFG_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              opcode;
        logic [CAP_W-1:0]  capture;
        logic [CLK_W-1:0]  clock_hz;
        logic              typed;
        logic [FREQ_W-1:0] frequency;
        logic [CAP_W-1:0]  period;
        logic              updated;
        logic              zero_period;
    } t_directed_row;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_wr_en     = 1'b0;
    logic [CLK_W-1:0]  i_cfg_wr_data   = '0;
    logic              i_in_valid      = 1'b0;
    logic              i_opcode        = OP_CAPTURE;
    logic [CAP_W-1:0]  i_capture_value = '0;
    logic              i_out_ready     = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [FREQ_W-1:0] o_frequency_hz;
    logic [CAP_W-1:0]  o_period_ticks;
    logic              o_updated;
    logic              o_zero_period;

    // Predictor state, mirrored from the reset values of the block.
    logic [CLK_W-1:0]  clock_hz_setting = CLK_RESET;
    logic              pair_open        = 1'b0;
    logic [CAP_W-1:0]  held_capture     = '0;
    logic [CAP_W-1:0]  last_period      = '0;
    logic [FREQ_W-1:0] last_frequency   = '0;

    t_meter_reading    expected_readings [$];
    int                readings_checked = 0;
    int                mismatch_count   = 0;

    t_directed_row     directed_rows [0:NUM_ROWS-1];

    capture_pair_frequency_meter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_capture_value (i_capture_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frequency_hz  (o_frequency_hz),
        .o_period_ticks  (o_period_ticks),
        .o_updated       (o_updated),
        .o_zero_period   (o_zero_period)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mostly short gaps, with runs of no gap and an occasional long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Advances the predictor by one accepted request and returns its reading.
    function automatic t_meter_reading predict_reading(logic opcode, logic [CAP_W-1:0] capture);
        t_meter_reading   reading;
        logic [CAP_W-1:0] span;
        logic [63:0]      scaled;
        reading = '0;
        if (opcode == OP_CLEAR) begin
            pair_open      = 1'b0;
            last_frequency = '0;
        end else if (!pair_open) begin
            held_capture = capture;
            pair_open    = 1'b1;
        end else begin
            span        = (capture - held_capture) & PERIOD_MASK;
            last_period = span;
            if (span == '0) begin
                last_frequency      = '0;
                reading.zero_period = 1'b1;
            end else begin
                scaled = (64'(clock_hz_setting) / 64'(span)) * 64'(PRESCALE_FACTOR);
                if (scaled > 64'(FREQ_MAX)) begin
                    scaled = 64'(FREQ_MAX);
                end
                last_frequency = scaled[FREQ_W-1:0];
            end
            reading.updated = 1'b1;
            pair_open       = 1'b0;
        end
        reading.frequency = last_frequency;
        reading.period    = last_period;
        return reading;
    endfunction

    task automatic send_request(input logic opcode, input logic [CAP_W-1:0] capture,
                                input logic typed, input t_meter_reading typed_reading);
        t_meter_reading predicted;
        int             gap;
        i_in_valid      <= 1'b1;
        i_opcode        <= opcode;
        i_capture_value <= capture;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_reading(opcode, capture);
        expected_readings.push_back(typed ? typed_reading : predicted);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The register is only written once every outstanding request has answered.
    task automatic write_timer_clock(input logic [CLK_W-1:0] clock_hz);
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= clock_hz;
        @(posedge i_clk);
        i_cfg_wr_en      <= 1'b0;
        clock_hz_setting = clock_hz;
    endtask

    initial begin : stimulus
        t_directed_row    row;
        logic             opcode;
        logic [CAP_W-1:0] capture;
        logic [CAP_W-1:0] delta;
        logic [CLK_W-1:0] clock_hz;
        directed_rows = '{
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0000, 28'd0, 1'b1, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0000, 28'd0, 1'b1, 30'd0, 16'd0, 1'b1, 1'b1},
            '{ROW_REQUEST,   OP_CAPTURE, 16'hFFFF, 28'd0, 1'b1, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0000, 28'd0, 1'b1, 30'd288000000, 16'd1,
              1'b1, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0000, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'hFFFF, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CLEAR,   16'hFFFF, 28'd0, 1'b1, 30'd0, 16'hFFFF, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h1234, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CLEAR,   16'h0000, 28'd0, 1'b1, 30'd0, 16'hFFFF, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h1000, 28'd0, 1'b1, 30'd0, 16'hFFFF, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h2000, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'hAAAA, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h5555, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_CFG_WRITE, OP_CAPTURE, 16'h0000, 28'd1, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0000, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0001, 28'd0, 1'b1, 30'd4, 16'd1, 1'b1, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0000, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0002, 28'd0, 1'b1, 30'd0, 16'd2, 1'b1, 1'b0},
            '{ROW_CFG_WRITE, OP_CAPTURE, 16'h0000, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0007, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0008, 28'd0, 1'b1, 30'd0, 16'd1, 1'b1, 1'b0},
            '{ROW_CFG_WRITE, OP_CAPTURE, 16'h0000, 28'hFFFFFFF, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'hFFFF, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0000, 28'd0, 1'b1, 30'd1073741820, 16'd1,
              1'b1, 1'b0},
            '{ROW_CFG_WRITE, OP_CAPTURE, 16'h0000, 28'd200000000, 1'b0, 30'd0, 16'd0,
              1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0000, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0},
            '{ROW_REQUEST,   OP_CAPTURE, 16'h0003, 28'd0, 1'b0, 30'd0, 16'd0, 1'b0, 1'b0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG_WRITE) begin
                write_timer_clock(row.clock_hz);
            end else begin
                send_request(row.opcode, row.capture, row.typed,
                             '{row.frequency, row.period, row.updated, row.zero_period});
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: clock_hz = CLK_W'($urandom_range(1, 200000000));
                1: clock_hz = 28'd200000000;
                2: clock_hz = CLK_W'($urandom_range(1, 1000));
                3: clock_hz = CLK_W'($urandom);
                4: clock_hz = 28'd1;
                default: clock_hz = CLK_RESET;
            endcase
            write_timer_clock(clock_hz);

            // Mostly well-formed pairs; the second capture lands at a chosen
            // distance from the first so that short, wrapping and zero periods all occur.
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                opcode  = OP_CAPTURE;
                capture = CAP_W'($urandom);
                if ($urandom_range(0, 11) == 0) begin
                    opcode = OP_CLEAR;
                end else if (pair_open) begin
                    case ($urandom_range(0, 9))
                        0:       delta = '0;
                        1:       delta = '1;
                        2, 3, 4: delta = CAP_W'($urandom_range(1, 16));
                        5, 6:    delta = CAP_W'($urandom_range(17, 4096));
                        default: delta = CAP_W'($urandom);
                    endcase
                    capture = held_capture + delta;
                end
                send_request(opcode, capture, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side: random stalls, plus two long holds that back the block up
    // until it stops taking requests.
    initial begin : result_sink
        int run;
        int stall;
        int long_holds;
        long_holds = 0;
        @(posedge i_clk);
        forever begin
            if ((long_holds == 0 && readings_checked >= 300) ||
                (long_holds == 1 && readings_checked >= 600)) begin
                long_holds++;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_meter_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: result with no request outstanding: freq %0d period %0d",
                         $time, o_frequency_hz, o_period_ticks);
                mismatch_count++;
            end else begin
                want = expected_readings.pop_front();
                readings_checked++;
                if (o_frequency_hz != want.frequency) begin
                    $display("%0t: frequency expected %0d actual %0d",
                             $time, want.frequency, o_frequency_hz);
                    mismatch_count++;
                end
                if (o_period_ticks != want.period) begin
                    $display("%0t: period expected %0d actual %0d",
                             $time, want.period, o_period_ticks);
                    mismatch_count++;
                end
                if (o_updated != want.updated) begin
                    $display("%0t: updated flag expected %0b actual %0b",
                             $time, want.updated, o_updated);
                    mismatch_count++;
                end
                if (o_zero_period != want.zero_period) begin
                    $display("%0t: zero period flag expected %0b actual %0b",
                             $time, want.zero_period, o_zero_period);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- capture_pair_frequency_meter.f -----
design/cpfm_pkg.sv
design/cpfm_dpath.sv
design/cpfm_ctrl.sv
design/capture_pair_frequency_meter.sv
test/tb_capture_pair_frequency_meter.sv
